### hw/rtl/indexed_list_engine_macros.svh
// assertion helpers shared by the rtl files
// every macro samples on clk and is held off while arst_n is low
`ifndef INDEXED_LIST_ENGINE_MACROS_SVH
`define INDEXED_LIST_ENGINE_MACROS_SVH

// condition must hold at every edge
`define ILE_ASSERT_ALWAYS(lbl, cond, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-edge implication
`define ILE_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error(msg);

// next-edge implication
`define ILE_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
else $error(msg);

`endif

### hw/rtl/ile_pkg.sv
`default_nettype none
package ile_pkg;

	// list geometry
	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// beat field widths
	localparam int OP_W      = 3;
	localparam int DATA_W    = 32;
	localparam int IDXF_W    = 5;
	localparam int STAT_W    = 2;
	localparam int POS_W     = 4;
	localparam int ENT_W     = 5;
	localparam int IN_BITS   = OP_W + DATA_W + IDXF_W;
	localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS  = STAT_W + DATA_W + POS_W + ENT_W;
	localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8;
	localparam int OUT_PAD_W = OUT_W - OUT_BITS;

	// common width for index and count compares
	localparam int CMP_W = (CNT_W > IDXF_W) ? CNT_W : IDXF_W;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT   = 3'd0,
		OP_DELETE   = 3'd1,
		OP_LOCATE   = 3'd2,
		OP_RETRIEVE = 3'd3,
		OP_SORTED   = 3'd4,
		OP_CLEAR    = 3'd5
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_BADINDEX = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// command broadcast to every cell
	typedef struct packed {
		logic              ins;
		logic              del;
		logic              sorted;
		logic [DATA_W-1:0] data;
		logic [CMP_W-1:0]  index;
		logic [CNT_W-1:0]  fill;
	} cell_cmd_t;

	typedef struct packed {
		status_t           status;
		logic [DATA_W-1:0] value;
		logic [POS_W-1:0]  position;
		logic [ENT_W-1:0]  entries;
	} result_t;

endpackage
`default_nettype wire

### hw/rtl/ile_cell.sv
`default_nettype none
module ile_cell (
	input  logic                           clk,
	input  ile_pkg::cell_cmd_t             cmd,
	input  logic [ile_pkg::IDX_W-1:0]      slot_id,
	input  logic [ile_pkg::DATA_W-1:0]     left_val,
	input  logic [ile_pkg::DATA_W-1:0]     right_val,
	input  logic                           left_ge,
	input  logic                           right_le,
	input  logic                           left_found,
	output logic [ile_pkg::DATA_W-1:0]     val,
	output logic                           ge,
	output logic                           le_any,
	output logic                           found,
	output logic                           hit
);
	import ile_pkg::*;

	logic [DATA_W-1:0] slot_q;
	logic [CMP_W-1:0]  id_ext;
	logic              live;
	logic              match;
	logic              le;

	// compare against the broadcast value
	always_comb begin
		id_ext = CMP_W'(slot_id);
		live   = id_ext < CMP_W'(cmd.fill);
		match  = live && (slot_q == cmd.data);
		le     = live && ($signed(slot_q) <= $signed(cmd.data));
	end

	// neighbor chains: at-or-after insert point, and first match from the left
	always_comb begin
		le_any = le | right_le;
		ge     = cmd.sorted ? !le_any : (id_ext >= cmd.index);
		found  = match | left_found;
		hit    = match & !left_found;
	end

	// shift right on insert, left on delete
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (left_ge) begin
				slot_q <= left_val;
			end else if (ge) begin
				slot_q <= cmd.data;
			end
		end else if (cmd.del && (id_ext >= cmd.index)) begin
			slot_q <= right_val;
		end
	end

	assign val = slot_q;

endmodule
`default_nettype wire

### hw/rtl/indexed_list_engine.sv
`default_nettype none
// Packed list of up to 16 signed 32-bit entries held in a row of cells, one
// entry per cell. A command beat on s_* carries op, data and index; each command
// returns exactly one result beat on m_* with status, value, position and the
// entry count after the command. Insert, sorted insert and delete shift all
// cells at once, and locate, sorted-insert placement and first-match
// selection ripple through the cell chain, which sets the clock period. The
// result is registered and shows in the cycle after the command beat; a new
// command is taken in the same cycle a waiting result is taken, so the block
// sustains one command per cycle while results are taken. Full lists report
// status 3 on insert, an insert index past the count or a delete or retrieve
// index at or past the count reports status 2, and a failed locate reports
// status 1. Op codes 6 and 7 change nothing and report status 0.
`include "indexed_list_engine_macros.svh"
module indexed_list_engine (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [ile_pkg::IN_W-1:0]   s_tdata,   // op[2:0], data[34:3], index[39:35]
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [ile_pkg::OUT_W-1:0]  m_tdata    // status[1:0], value[33:2],
	                                              // position[37:34], entries[42:38]
);
	import ile_pkg::*;

	logic [CNT_W-1:0]  fill_q;
	logic              out_valid_q;
	result_t           out_q;

	logic              acc;
	op_t               op;
	logic [DATA_W-1:0] data;
	logic [CMP_W-1:0]  idx_ext;
	logic [CMP_W-1:0]  fill_ext;
	logic [IDX_W-1:0]  rd_sel;
	logic              ins_ok;
	logic              del_ok;
	status_t           st;
	logic [DATA_W-1:0] value;
	logic [CNT_W-1:0]  fill_nxt;
	logic [IDX_W-1:0]  pos_acc;
	logic [CMP_W-1:0]  pos_ext;
	logic [CMP_W-1:0]  ent_ext;
	cell_cmd_t         cmd;

	logic [DATA_W-1:0] vals [DEPTH];
	logic [DEPTH-1:0]  ge_v;
	logic [DEPTH-1:0]  le_v;
	logic [DEPTH-1:0]  found_v;
	logic [DEPTH-1:0]  hit;

	// beat handshake
	assign s_tready = !out_valid_q || m_tready;
	assign acc      = s_tvalid && s_tready;

	// unpack command beat
	always_comb begin
		op       = op_t'(s_tdata[OP_W-1:0]);
		data     = s_tdata[OP_W +: DATA_W];
		idx_ext  = CMP_W'(s_tdata[OP_W+DATA_W +: IDXF_W]);
		fill_ext = CMP_W'(fill_q);
		rd_sel   = idx_ext[IDX_W-1:0];
	end

	// status and new count
	always_comb begin
		st       = ST_OK;
		value    = '0;
		fill_nxt = fill_q;
		ins_ok   = 1'b0;
		del_ok   = 1'b0;
		unique case (op)
			OP_INSERT: begin
				if (fill_q == CNT_W'(DEPTH)) begin
					st = ST_FULL;
				end else if (idx_ext > fill_ext) begin
					st = ST_BADINDEX;
				end else begin
					ins_ok   = 1'b1;
					fill_nxt = fill_q + 1'b1;
				end
			end
			OP_DELETE: begin
				if (idx_ext >= fill_ext) begin
					st = ST_BADINDEX;
				end else begin
					del_ok   = 1'b1;
					fill_nxt = fill_q - 1'b1;
				end
			end
			OP_LOCATE: begin
				st = found_v[DEPTH-1] ? ST_OK : ST_NOTFOUND;
			end
			OP_RETRIEVE: begin
				if (idx_ext >= fill_ext) begin
					st = ST_BADINDEX;
				end else begin
					value = vals[rd_sel];
				end
			end
			OP_SORTED: begin
				if (fill_q == CNT_W'(DEPTH)) begin
					st = ST_FULL;
				end else begin
					ins_ok   = 1'b1;
					fill_nxt = fill_q + 1'b1;
				end
			end
			OP_CLEAR: begin
				fill_nxt = '0;
			end
			default: begin
			end
		endcase
	end

	// first-match index from the one-hot hit vector
	always_comb begin
		pos_acc = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (hit[i]) begin
				pos_acc = pos_acc | IDX_W'(i);
			end
		end
		pos_ext = (op == OP_LOCATE) ? CMP_W'(pos_acc) : '0;
		ent_ext = CMP_W'(fill_nxt);
	end

	// command broadcast
	always_comb begin
		cmd.ins    = acc && ins_ok;
		cmd.del    = acc && del_ok;
		cmd.sorted = (op == OP_SORTED);
		cmd.data   = data;
		cmd.index  = idx_ext;
		cmd.fill   = fill_q;
	end

	// row of cells
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [DATA_W-1:0] lv;
		logic [DATA_W-1:0] rv;
		logic              lg;
		logic              rl;
		logic              lf;

		if (g == 0) begin : g_first
			assign lv = '0;
			assign lg = 1'b0;
			assign lf = 1'b0;
		end else begin : g_mid
			assign lv = vals[g-1];
			assign lg = ge_v[g-1];
			assign lf = found_v[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign rv = vals[g];
			assign rl = 1'b0;
		end else begin : g_inner
			assign rv = vals[g+1];
			assign rl = le_v[g+1];
		end

		ile_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.slot_id    (IDX_W'(g)),
			.left_val   (lv),
			.right_val  (rv),
			.left_ge    (lg),
			.right_le   (rl),
			.left_found (lf),
			.val        (vals[g]),
			.ge         (ge_v[g]),
			.le_any     (le_v[g]),
			.found      (found_v[g]),
			.hit        (hit[g])
		);
	end

	// count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				fill_q <= fill_nxt;
			end
			if (acc) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (acc) begin
			out_q.status   <= st;
			out_q.value    <= value;
			out_q.position <= pos_ext[POS_W-1:0];
			out_q.entries  <= ent_ext[ENT_W-1:0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_q.entries, out_q.position,
	                   out_q.value, out_q.status};

	// checks
	`ILE_ASSERT_ALWAYS(a_fill_range, fill_q <= CNT_W'(DEPTH), "count exceeds depth")
	`ILE_ASSERT_ALWAYS(a_single_hit, $onehot0(hit), "more than one first match")
	`ILE_ASSERT_IMP(a_full_status, acc && st == ST_FULL, fill_q == CNT_W'(DEPTH),
		"full with room left")
	`ILE_ASSERT_NEXT(a_insert_grows, acc && ins_ok, fill_q == $past(fill_q) + 1'b1,
		"insert count slip")
	`ILE_ASSERT_NEXT(a_clear_empties, acc && op == OP_CLEAR,
		fill_q == '0 && out_q.entries == '0, "clear left entries")

endmodule
`default_nettype wire
